// ===== rtl/mcpf_pkg.sv =====
// Shared constants, types and helpers for the multi-channel pipe FIFO.
package mcpf_pkg;

    // Pool size and per-channel buffer size
    localparam int NUM_CHANNELS = 32;
    localparam int BUF_DEPTH    = 1024;

    localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int PTR_W     = $clog2(BUF_DEPTH);
    localparam int FILL_W    = $clog2(BUF_DEPTH + 1);
    localparam int BYTE_AW   = CH_W + PTR_W;
    localparam int CREATE_LIM = (NUM_CHANNELS < 32) ? NUM_CHANNELS : 32;

    // Operation codes
    localparam logic [2:0] OP_CREATE    = 3'd0;
    localparam logic [2:0] OP_WRITE     = 3'd1;
    localparam logic [2:0] OP_READ      = 3'd2;
    localparam logic [2:0] OP_CLOSE_RD  = 3'd3;
    localparam logic [2:0] OP_CLOSE_WR  = 3'd4;
    localparam logic [2:0] OP_POLL_RD   = 3'd5;
    localparam logic [2:0] OP_POLL_WR   = 3'd6;

    // Status codes
    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_NOFREE  = 3'd1;
    localparam logic [2:0] STAT_BLOCK   = 3'd2;
    localparam logic [2:0] STAT_EOF     = 3'd3;
    localparam logic [2:0] STAT_BROKEN  = 3'd4;
    localparam logic [2:0] STAT_INVALID = 3'd5;

    // Poll flag bits
    localparam logic [5:0] PF_IN   = 6'h01;
    localparam logic [5:0] PF_OUT  = 6'h04;
    localparam logic [5:0] PF_ERR  = 6'h08;
    localparam logic [5:0] PF_HUP  = 6'h10;
    localparam logic [5:0] PF_NVAL = 6'h20;

    // One entry of the pointer memory
    typedef struct packed {
        logic [PTR_W-1:0]  wptr;
        logic [PTR_W-1:0]  rptr;
        logic [FILL_W-1:0] fill;
    } ptr_entry_t;

    // One result word
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] read_byte;
        logic [4:0] channel_out;
        logic [5:0] poll_flags;
        logic       broken_pipe_signal;
    } result_t;

    // Map the 5-bit channel field onto a memory index
    function automatic logic [CH_W-1:0] ch_index(input logic [4:0] c);
        logic [6:0] ext;
        ext = {2'b00, c};
        return ext[CH_W-1:0];
    endfunction

    // Channel field names an existing channel
    function automatic logic ch_in_range(input logic [4:0] c);
        return ({2'b00, c} < 7'(NUM_CHANNELS));
    endfunction

    // Advance a buffer pointer with wrap at the buffer depth
    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(BUF_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

endpackage

// ===== rtl/mcpf_req_if.sv =====
// Request channel: one pipe operation per word.
interface mcpf_req_if
    import mcpf_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [4:0] channel;
    logic [7:0] data_byte;
    logic       want_ready;

    modport source (output valid, output operation, output channel,
                    output data_byte, output want_ready, input ready);
    modport sink   (input valid, input operation, input channel,
                    input data_byte, input want_ready, output ready);
endinterface

// ===== rtl/mcpf_rsp_if.sv =====
// Response channel: one result word per operation.
interface mcpf_rsp_if
    import mcpf_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] read_byte;
    logic [4:0] channel_out;
    logic [5:0] poll_flags;
    logic       broken_pipe_signal;

    modport source (output valid, output status, output read_byte,
                    output channel_out, output poll_flags,
                    output broken_pipe_signal, input ready);
    modport sink   (input valid, input status, input read_byte,
                    input channel_out, input poll_flags,
                    input broken_pipe_signal, output ready);
endinterface

// ===== rtl/mcpf_ptr_mem.sv =====
// Per-channel pointer and fill-level memory, registered read.
module mcpf_ptr_mem
    import mcpf_pkg::*;
(
    input  logic            clk,
    input  logic            rd_en,
    input  logic [CH_W-1:0] rd_addr,
    output ptr_entry_t      rd_data,
    input  logic            wr_en,
    input  logic [CH_W-1:0] wr_addr,
    input  ptr_entry_t      wr_data
);

    ptr_entry_t mem [NUM_CHANNELS];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/mcpf_byte_mem.sv =====
// Byte store for all channel buffers, registered read.
module mcpf_byte_mem
    import mcpf_pkg::*;
(
    input  logic               clk,
    input  logic               rd_en,
    input  logic [BYTE_AW-1:0] rd_addr,
    output logic [7:0]         rd_data,
    input  logic               wr_en,
    input  logic [BYTE_AW-1:0] wr_addr,
    input  logic [7:0]         wr_data
);

    logic [7:0] mem [2**BYTE_AW];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/multi_channel_pipe_fifo_core.sv =====
// Multi-channel pipe FIFO: a pool of byte pipes driven one operation at a time.
//
// Use: the req channel carries one operation word (create, write, read,
// close read end, close write end, poll read end, poll write end) with a
// channel index, a data byte and a poll readiness request. The rsp channel
// returns exactly one result word per operation, in order: status, the byte
// read, the channel claimed by create, poll flags and a broken-pipe flag.
// Timing: an accepted request passes through EXEC and SEND before its result
// is registered; a successful read also passes through FETCH for the byte store read.
// The block takes one operation at a time; the pointer memory read and the
// byte store read are each registered, and an operation completes its
// read-modify-write before the next is taken.
// Reset: all channels are free; pointer and byte memories hold no reset
// value and create sets up the pointer entry. No clearing pass is needed.
// Stall: the result sits in an output register; while rsp.ready is low the
// block still takes and executes the next operation and holds its result
// until the output register frees, and only then accepts again.
module multi_channel_pipe_fifo_core
    import mcpf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    mcpf_req_if.sink   req,
    mcpf_rsp_if.source rsp
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_FETCH = 2'd2;
    localparam logic [1:0] S_SEND  = 2'd3;

    logic [1:0] state_reg, state_next;

    // Captured operation
    logic [2:0]      op_reg;
    logic [4:0]      ch_reg;
    logic [7:0]      data_reg;
    logic            want_reg;

    // Per-channel end and activity flags
    logic [NUM_CHANNELS-1:0] active_reg, active_next;
    logic [NUM_CHANNELS-1:0] ropen_reg, ropen_next;
    logic [NUM_CHANNELS-1:0] wopen_reg, wopen_next;

    // Result holding and output registers
    result_t pend_reg, pend_next;
    result_t out_reg;
    logic    out_valid_reg;

    // Memory ports
    logic               ptr_rd_en;
    ptr_entry_t         ptr_rd_data;
    logic               ptr_wr_en;
    logic [CH_W-1:0]    ptr_wr_addr;
    ptr_entry_t         ptr_wr_data;
    logic               byte_rd_en;
    logic [BYTE_AW-1:0] byte_rd_addr;
    logic [7:0]         byte_rd_data;
    logic               byte_wr_en;

    logic               accept;
    logic               out_free;
    logic [CH_W-1:0]    idx;
    logic               live;
    logic               found;
    logic [CH_W-1:0]    free_idx;
    ptr_entry_t         ent;

    assign accept   = req.valid & req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || rsp.ready;

    assign idx  = ch_index(ch_reg);
    assign live = ch_in_range(ch_reg) && active_reg[idx];
    assign ent  = ptr_rd_data;

    assign ptr_rd_en = accept;

    mcpf_ptr_mem u_ptr_mem (
        .clk     (clk),
        .rd_en   (ptr_rd_en),
        .rd_addr (ch_index(req.channel)),
        .rd_data (ptr_rd_data),
        .wr_en   (ptr_wr_en),
        .wr_addr (ptr_wr_addr),
        .wr_data (ptr_wr_data)
    );

    mcpf_byte_mem u_byte_mem (
        .clk     (clk),
        .rd_en   (byte_rd_en),
        .rd_addr (byte_rd_addr),
        .rd_data (byte_rd_data),
        .wr_en   (byte_wr_en),
        .wr_addr ({idx, ent.wptr}),
        .wr_data (data_reg)
    );

    // Find the lowest free channel that create may claim
    always_comb
    begin
        found    = 1'b0;
        free_idx = '0;
        for (int i = CREATE_LIM - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                found    = 1'b1;
                free_idx = CH_W'(i);
            end
        end
    end

    // Execute the operation against the fetched pointer entry
    always_comb
    begin
        state_next   = state_reg;
        active_next  = active_reg;
        ropen_next   = ropen_reg;
        wopen_next   = wopen_reg;
        pend_next    = pend_reg;
        ptr_wr_en    = 1'b0;
        ptr_wr_addr  = idx;
        ptr_wr_data  = ent;
        byte_wr_en   = 1'b0;
        byte_rd_en   = 1'b0;
        byte_rd_addr = {idx, ent.rptr};

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                pend_next  = '0;
                state_next = S_SEND;
                case (op_reg)
                    OP_CREATE:
                    begin
                        if (found)
                        begin
                            ptr_wr_en             = 1'b1;
                            ptr_wr_addr           = free_idx;
                            ptr_wr_data           = '0;
                            active_next[free_idx] = 1'b1;
                            ropen_next[free_idx]  = 1'b1;
                            wopen_next[free_idx]  = 1'b1;
                            pend_next.status      = STAT_OK;
                            pend_next.channel_out = 5'(free_idx);
                        end
                        else
                        begin
                            pend_next.status = STAT_NOFREE;
                        end
                    end

                    OP_WRITE:
                    begin
                        if (!live || !wopen_reg[idx])
                        begin
                            pend_next.status = STAT_INVALID;
                        end
                        else if (!ropen_reg[idx])
                        begin
                            pend_next.status             = STAT_BROKEN;
                            pend_next.broken_pipe_signal = 1'b1;
                        end
                        else if (ent.fill >= FILL_W'(BUF_DEPTH))
                        begin
                            pend_next.status = STAT_BLOCK;
                        end
                        else
                        begin
                            byte_wr_en       = 1'b1;
                            ptr_wr_en        = 1'b1;
                            ptr_wr_data.wptr = next_ptr(ent.wptr);
                            ptr_wr_data.fill = ent.fill + FILL_W'(1);
                        end
                    end

                    OP_READ:
                    begin
                        if (!live || !ropen_reg[idx])
                        begin
                            pend_next.status = STAT_INVALID;
                        end
                        else if (ent.fill == '0)
                        begin
                            pend_next.status = wopen_reg[idx] ? STAT_BLOCK : STAT_EOF;
                        end
                        else
                        begin
                            byte_rd_en       = 1'b1;
                            ptr_wr_en        = 1'b1;
                            ptr_wr_data.rptr = next_ptr(ent.rptr);
                            ptr_wr_data.fill = ent.fill - FILL_W'(1);
                            state_next       = S_FETCH;
                        end
                    end

                    OP_CLOSE_RD, OP_CLOSE_WR:
                    begin
                        if (!live)
                        begin
                            pend_next.status = STAT_INVALID;
                        end
                        else
                        begin
                            if (op_reg == OP_CLOSE_RD)
                            begin
                                ropen_next[idx] = 1'b0;
                            end
                            else
                            begin
                                wopen_next[idx] = 1'b0;
                            end
                            // free the channel once both ends are closed
                            if (!ropen_next[idx] && !wopen_next[idx])
                            begin
                                active_next[idx] = 1'b0;
                            end
                        end
                    end

                    OP_POLL_RD:
                    begin
                        if (!live || !ropen_reg[idx])
                        begin
                            pend_next.status     = STAT_INVALID;
                            pend_next.poll_flags = PF_NVAL;
                        end
                        else
                        begin
                            if (want_reg && (ent.fill != '0 || !wopen_reg[idx]))
                            begin
                                pend_next.poll_flags = pend_next.poll_flags | PF_IN;
                            end
                            if (!wopen_reg[idx])
                            begin
                                pend_next.poll_flags = pend_next.poll_flags | PF_HUP;
                            end
                        end
                    end

                    OP_POLL_WR:
                    begin
                        if (!live || !wopen_reg[idx])
                        begin
                            pend_next.status     = STAT_INVALID;
                            pend_next.poll_flags = PF_NVAL;
                        end
                        else
                        begin
                            if (want_reg && ropen_reg[idx] &&
                                ent.fill < FILL_W'(BUF_DEPTH))
                            begin
                                pend_next.poll_flags = pend_next.poll_flags | PF_OUT;
                            end
                            if (!ropen_reg[idx])
                            begin
                                pend_next.poll_flags = pend_next.poll_flags | PF_ERR | PF_HUP;
                            end
                        end
                    end

                    default:
                    begin
                        pend_next.status = STAT_INVALID;
                    end
                endcase
            end

            S_FETCH:
            begin
                pend_next.read_byte = byte_rd_data;
                state_next          = S_SEND;
            end

            S_SEND:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Advance control state, channel flags and the output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= '0;
            ropen_reg     <= '0;
            wopen_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            ropen_reg  <= ropen_next;
            wopen_reg  <= wopen_next;
            if (state_reg == S_SEND && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the request word, the pending result and the output word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= req.operation;
            ch_reg   <= req.channel;
            data_reg <= req.data_byte;
            want_reg <= req.want_ready;
        end
        pend_reg <= pend_next;
        if (state_reg == S_SEND && out_free)
        begin
            out_reg <= pend_reg;
        end
    end

    assign rsp.valid              = out_valid_reg;
    assign rsp.status             = out_reg.status;
    assign rsp.read_byte          = out_reg.read_byte;
    assign rsp.channel_out        = out_reg.channel_out;
    assign rsp.poll_flags         = out_reg.poll_flags;
    assign rsp.broken_pipe_signal = out_reg.broken_pipe_signal;

endmodule
